>>> hdl/xos_pkg.sv
// Shared types and constants for the XML output character sanitizer.
package xos_pkg;

    localparam int UNIT_W = 16;
    localparam int CNT_W  = 3;

    localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [UNIT_W-1:0] CH_LT     = 16'h003C;
    localparam logic [UNIT_W-1:0] CH_GT     = 16'h003E;

    localparam logic [UNIT_W-1:0] XML_LO1_MIN = 16'h0020;
    localparam logic [UNIT_W-1:0] XML_LO1_MAX = 16'hD7FF;
    localparam logic [UNIT_W-1:0] XML_LO2_MIN = 16'hE000;
    localparam logic [UNIT_W-1:0] XML_LO2_MAX = 16'hFFFD;
    localparam logic [UNIT_W-1:0] HIGH_MIN    = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_MAX    = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_MIN     = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_MAX     = 16'hDFFF;

    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_PAIR = 3'd2;
    localparam logic [CNT_W-1:0] CNT_ESC  = 3'd4;

    // Tracking state carried from one code unit to the next.
    typedef struct packed {
        logic              in_tag;
        logic              in_quote;
        logic              quote_is_double;
        logic              high_pending;
        logic [UNIT_W-1:0] held_high_unit;
    } t_track;

    // Results caused by one input code unit.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic              esc;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
    } t_step_res;

    // Units of the &gt; escape, in output order.
    function automatic logic [UNIT_W-1:0] gt_escape_unit(input logic [1:0] idx);
        logic [UNIT_W-1:0] u;
        case (idx)
            2'd0:    u = 16'h0026;
            2'd1:    u = 16'h0067;
            2'd2:    u = 16'h0074;
            2'd3:    u = 16'h003B;
            default: u = 16'h003B;
        endcase
        return u;
    endfunction

endpackage

>>> hdl/xos_if.sv
// Stream interfaces for the sanitizer input and output channels.
interface xos_in_if;
    logic                         valid;
    logic                         ready;
    logic [xos_pkg::UNIT_W-1:0]   code_unit;
    logic                         end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface xos_out_if;
    logic                         valid;
    logic                         ready;
    logic [xos_pkg::UNIT_W-1:0]   out_unit;
    logic                         run_last;

    modport source (output valid, output out_unit, output run_last, input ready);
    modport sink   (input valid, input out_unit, input run_last, output ready);
endinterface

>>> hdl/xos_step.sv
// Per-unit decision logic: tag and quote tracking, filtering and escape selection.
module xos_step (
    input  xos_pkg::t_track             i_cur,
    input  logic [xos_pkg::UNIT_W-1:0]  i_unit,
    input  logic                        i_eot,
    output xos_pkg::t_track             o_next,
    output xos_pkg::t_step_res          o_res
);

    logic           is_low;
    logic           is_high;
    logic           is_xml;
    logic           pair;
    logic           is_dq;
    xos_pkg::t_track upd;
    logic           esc;

    assign is_low  = (i_unit >= xos_pkg::LOW_MIN) && (i_unit <= xos_pkg::LOW_MAX);
    assign is_high = (i_unit >= xos_pkg::HIGH_MIN) && (i_unit <= xos_pkg::HIGH_MAX);
    assign is_xml  = (i_unit == xos_pkg::CH_TAB) || (i_unit == xos_pkg::CH_LF)
                  || (i_unit == xos_pkg::CH_CR)
                  || ((i_unit >= xos_pkg::XML_LO1_MIN) && (i_unit <= xos_pkg::XML_LO1_MAX))
                  || ((i_unit >= xos_pkg::XML_LO2_MIN) && (i_unit <= xos_pkg::XML_LO2_MAX));
    assign pair    = i_cur.high_pending && is_low;
    assign is_dq   = (i_unit == xos_pkg::CH_DQUOTE);

    always_comb begin
        upd              = i_cur;
        upd.high_pending = 1'b0;
        esc              = 1'b0;
        o_res.cnt        = xos_pkg::CNT_NONE;
        o_res.esc        = 1'b0;
        o_res.u0         = i_unit;
        o_res.u1         = i_unit;

        if (pair) begin
            // The held high surrogate and this low one go out together.
            o_res.cnt = xos_pkg::CNT_PAIR;
            o_res.u0  = i_cur.held_high_unit;
        end else begin
            if (i_unit == xos_pkg::CH_LT) begin
                upd.in_tag = 1'b1;
            end else if (i_unit == xos_pkg::CH_GT) begin
                if (i_cur.in_quote || !i_cur.in_tag) begin
                    esc = 1'b1;
                end else begin
                    upd.in_tag = 1'b0;
                end
            end else if (is_dq || (i_unit == xos_pkg::CH_SQUOTE)) begin
                if (i_cur.in_tag) begin
                    if (!i_cur.in_quote) begin
                        upd.in_quote        = 1'b1;
                        upd.quote_is_double = is_dq;
                    end else if (i_cur.quote_is_double == is_dq) begin
                        upd.in_quote = 1'b0;
                    end
                end
            end

            if (esc) begin
                o_res.cnt = xos_pkg::CNT_ESC;
                o_res.esc = 1'b1;
            end else if (upd.in_tag && !upd.in_quote) begin
                o_res.cnt = xos_pkg::CNT_ONE;
            end else if (is_xml) begin
                o_res.cnt = xos_pkg::CNT_ONE;
            end else if (is_high) begin
                upd.high_pending   = 1'b1;
                upd.held_high_unit = i_unit;
            end
        end

        if (i_eot) begin
            o_next = '0;
        end else begin
            o_next = upd;
        end
    end

endmodule

>>> hdl/xos_emit.sv
// Result register that plays out the one to four units of one input.
module xos_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  xos_pkg::t_step_res  i_res,
    output logic                o_can_load,
    xos_out_if.source           o_out
);

    logic                       r_valid;
    logic                       r_esc;
    logic [xos_pkg::UNIT_W-1:0] r_u0;
    logic [xos_pkg::UNIT_W-1:0] r_u1;
    logic [xos_pkg::CNT_W-1:0]  r_cnt;
    logic [1:0]                 r_idx;
    logic                       last;
    logic                       done;

    assign last       = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign done       = r_valid && o_out.ready && last;
    assign o_can_load = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load && o_can_load) begin
            r_valid <= (i_res.cnt != xos_pkg::CNT_NONE);
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && o_out.ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_esc <= i_res.esc;
            r_u0  <= i_res.u0;
            r_u1  <= i_res.u1;
            r_cnt <= i_res.cnt;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.run_last = last;
    assign o_out.out_unit = r_esc ? xos_pkg::gt_escape_unit(r_idx)
                          : (r_idx[0] ? r_u1 : r_u0);

endmodule

>>> hdl/xml_output_char_sanitizer_core.sv
// Top level of the XML output character sanitizer.
// One UTF-16 code unit enters per transaction and passes through the input register and then
// the result register before its output units leave. Units that yield zero or one output unit
// stream at one input per cycle while the output is ready; a paired surrogate (two units) or an
// escaped '>' (the four units of "&gt;") holds the pipeline, since the single result register
// hands out one unit per cycle. The last unit caused by each input carries run_last; an input
// that yields nothing produces no transaction. A unit flagged end_of_text returns all tag, quote
// and surrogate tracking to its reset state, dropping any high surrogate still held.
module xml_output_char_sanitizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xos_in_if.sink     i_in,
    xos_out_if.source  o_out
);

    logic                       r_in_valid;
    logic [xos_pkg::UNIT_W-1:0] r_in_unit;
    logic                       r_in_eot;
    xos_pkg::t_track            r_track;
    xos_pkg::t_track            n_track;
    xos_pkg::t_step_res         step_res;
    logic                       can_load;
    logic                       take;

    assign take       = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_unit <= i_in.code_unit;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
        end else if (take) begin
            r_track <= n_track;
        end
    end

    xos_step u_step (
        .i_cur  (r_track),
        .i_unit (r_in_unit),
        .i_eot  (r_in_eot),
        .o_next (n_track),
        .o_res  (step_res)
    );

    xos_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (step_res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // A quoted attribute value only exists inside a tag.
    a_quote_in_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_track.in_quote |-> r_track.in_tag)
        else $error("quote state set outside a tag");

    // A held unit is always a high surrogate.
    a_held_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_track.high_pending |-> (r_track.held_high_unit[15:10] == 6'b110110))
        else $error("held unit is not a high surrogate");

    // The end of a string clears all tracking state.
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_in_eot) |=> (r_track == '0))
        else $error("tracking state not cleared at end of text");

    // An ampersand that ends a run never comes from the escape sequence, which starts with one.
    a_last_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_last && (o_out.out_unit == 16'h0026)) |-> !u_emit.r_esc)
        else $error("escape sequence ended early");

endmodule
